// File: sv/mpvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpvd_pkg
// Shared types, codes and helpers of the polyphonic voice dispatcher.
// ----------------------------------------------------------------------------
package mpvd_pkg;

  localparam int unsigned MAX_SYNTHS_DEF     = 16;
  localparam int unsigned MAX_NOTES_EACH_DEF = 6;
  localparam int unsigned VOICE_SLOTS_DEF    = 96;

  localparam int unsigned SYN_W  = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned AGE_W  = 32;
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 5;

  localparam logic [31:0] RANDOM_SEED = 32'h9E37_79B9;

  localparam logic [CFG_IW-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COUNT  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_FIRST  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_NOTES  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MODE   = 3'd4;

  localparam logic [1:0] MODE_OLDEST  = 2'd0;
  localparam logic [1:0] MODE_DROP    = 2'd1;
  localparam logic [1:0] MODE_QUIET   = 2'd2;
  localparam logic [1:0] MODE_RANDOM  = 2'd3;

  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_SYSTEM   = 4'hF;

  typedef struct packed {
    logic             active;
    logic [3:0]       src;
    logic [6:0]       note;
    logic [6:0]       vel;
    logic [SYN_W-1:0] synth;
    logic [AGE_W-1:0] age;
  } voice_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [4:0]       first;
    logic [2:0]       notes;
    logic [1:0]       mode;
  } eff_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

  function automatic logic [31:0] xorshift(input logic [31:0] w);
    logic [31:0] x;
    x = (w == 32'd0) ? RANDOM_SEED : w;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// File: sv/mpvd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpvd_cell
// One voice slot of the rotating voice ring.
// ----------------------------------------------------------------------------
module mpvd_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpvd_pkg::cell_ctl_t ctl_i,
  input  mpvd_pkg::voice_t    d_i,
  output mpvd_pkg::voice_t    q_o
);

  logic             act_q;
  mpvd_pkg::voice_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (ctl_i.clr) begin
      act_q <= 1'b0;
    end else if (ctl_i.shift) begin
      act_q <= d_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      data_q <= d_i;
    end
  end

  always_comb begin
    q_o        = data_q;
    q_o.active = act_q;
  end

endmodule

// File: sv/mpvd_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpvd_mod
// Bit-serial remainder of a 32-bit word by a narrow divisor.
// ----------------------------------------------------------------------------
module mpvd_mod #(
  parameter int unsigned DIV_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] rem_o
);

  logic             busy_q, done_q;
  logic [4:0]       cnt_q;
  logic [31:0]      dvd_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W:0]   trial;

  assign trial = {rem_q, dvd_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_q <= DIV_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_q <= trial[DIV_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/midi_poly_voice_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_poly_voice_dispatcher
// Round-robin note dispatch over several synths with voice stealing.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | status_byte, data_one, data_two
//   out     | output    | out_valid_o/out_ready_i | out_status .. last_of_run
//   cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// The voice table is a ring of VOICE_SLOTS cells rotating one slot per cycle
// past a single compare and write head, while a scan or write pass runs.
// Note-on: a synth search, then, unless the note is dropped, a scan pass and
// a write pass. Note-off: a scan pass and a write pass. Random steal: three
// passes with a remainder step between the first two. Other voice messages:
// one cycle per synth after the accepting cycle, while the output is free.
// Reset needs no clearing pass; a stalled output holds the block in its last step.
// ----------------------------------------------------------------------------
module midi_poly_voice_dispatcher #(
  parameter int unsigned MAX_SYNTHS     = mpvd_pkg::MAX_SYNTHS_DEF,
  parameter int unsigned MAX_NOTES_EACH = mpvd_pkg::MAX_NOTES_EACH_DEF,
  parameter int unsigned VOICE_SLOTS    = mpvd_pkg::VOICE_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mpvd_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [mpvd_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  status_byte_i,
  input  logic [6:0]                  data_one_i,
  input  logic [6:0]                  data_two_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_status_o,
  output logic [6:0]                  out_data_one_o,
  output logic [6:0]                  out_data_two_o,
  output logic                        has_message_o,
  output logic                        handled_o,
  output logic                        last_of_run_o
);

  localparam int unsigned IW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(VOICE_SLOTS + 1);
  localparam int unsigned SW = (MAX_SYNTHS > 1) ? $clog2(MAX_SYNTHS) : 1;
  localparam int unsigned NW = $clog2(MAX_NOTES_EACH + 1);
  localparam int unsigned YW = mpvd_pkg::SYN_W;
  localparam int unsigned KW = mpvd_pkg::CNT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RR     = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_WRITE  = 4'd5;
  localparam logic [3:0] S_EMIT_A = 4'd6;
  localparam logic [3:0] S_EMIT_B = 4'd7;
  localparam logic [3:0] S_NOMSG  = 4'd8;
  localparam logic [3:0] S_BCAST  = 4'd9;

  localparam logic [2:0] OP_OFF  = 3'd0;
  localparam logic [2:0] OP_FREE = 3'd1;
  localparam logic [2:0] OP_VICT = 3'd2;
  localparam logic [2:0] OP_CNT  = 3'd3;
  localparam logic [2:0] OP_KTH  = 3'd4;

  function automatic mpvd_pkg::eff_t eff_calc(input logic [4:0] c, input logic [4:0] f,
                                              input logic [2:0] n, input logic [1:0] m);
    logic [4:0]     cc, ff;
    logic [2:0]     nn;
    mpvd_pkg::eff_t e;
    cc = (c == 5'd0) ? 5'd1 : ((32'(c) > MAX_SYNTHS) ? 5'(MAX_SYNTHS) : c);
    ff = (f == 5'd0) ? 5'd1 : ((f > 5'd16) ? 5'd16 : f);
    if (({1'b0, ff} + {1'b0, cc}) > 6'd17) begin
      ff = 5'(6'd17 - {1'b0, cc});
    end
    nn = (n == 3'd0) ? 3'd1 : ((32'(n) > MAX_NOTES_EACH) ? 3'(MAX_NOTES_EACH) : n);
    e.count = cc;
    e.first = ff;
    e.notes = nn;
    e.mode  = m;
    return e;
  endfunction

  function automatic logic [YW-1:0] wrap_next(input logic [YW-1:0] s, input logic [KW-1:0] c);
    logic [KW-1:0] t;
    t = KW'({1'b0, s}) + KW'(1);
    return (t == c) ? '0 : YW'(t);
  endfunction

  // configuration
  logic           en_q;
  logic [4:0]     rcount_q, rfirst_q;
  logic [2:0]     rnotes_q;
  logic [1:0]     rmode_q;
  logic [4:0]     ccount, cfirst;
  logic [2:0]     cnotes;
  logic [1:0]     cmode;
  mpvd_pkg::eff_t eff, cand;
  logic           cfg_hit, cfg_clr;

  assign eff = eff_calc(rcount_q, rfirst_q, rnotes_q, rmode_q);

  always_comb begin
    ccount  = rcount_q;
    cfirst  = rfirst_q;
    cnotes  = rnotes_q;
    cmode   = rmode_q;
    cfg_hit = 1'b0;
    case (cfg_idx_i)
      mpvd_pkg::REG_COUNT: begin
        ccount  = cfg_data_i;
        cfg_hit = cfg_we_i;
      end
      mpvd_pkg::REG_FIRST: begin
        cfirst  = cfg_data_i;
        cfg_hit = cfg_we_i;
      end
      mpvd_pkg::REG_NOTES: begin
        cnotes  = cfg_data_i[2:0];
        cfg_hit = cfg_we_i;
      end
      mpvd_pkg::REG_MODE: begin
        cmode   = cfg_data_i[1:0];
        cfg_hit = cfg_we_i;
      end
      default: cfg_hit = 1'b0;
    endcase
  end

  assign cand    = eff_calc(ccount, cfirst, cnotes, cmode);
  assign cfg_clr = cfg_hit && (cand != eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      rcount_q <= 5'd1;
      rfirst_q <= 5'd1;
      rnotes_q <= 3'd1;
      rmode_q  <= mpvd_pkg::MODE_OLDEST;
    end else begin
      if (cfg_we_i && (cfg_idx_i == mpvd_pkg::REG_ENABLE)) begin
        en_q <= cfg_data_i[0];
      end
      if (cfg_hit) begin
        rcount_q <= ccount;
        rfirst_q <= cfirst;
        rnotes_q <= cnotes;
        rmode_q  <= cmode;
      end
    end
  end

  // voice ring
  mpvd_pkg::voice_t    row_q   [VOICE_SLOTS];
  mpvd_pkg::voice_t    cell_in [VOICE_SLOTS];
  mpvd_pkg::voice_t    head, tail, new_v;
  mpvd_pkg::cell_ctl_t cell_ctl;

  // control
  logic [3:0]      st_q, st_d;
  logic [2:0]      op_q, op_d;
  logic [7:0]      in_status_q;
  logic [6:0]      in_d1_q, in_d2_q;
  logic            hdl_q, hdl_d;
  logic [YW-1:0]   tgt_q, tgt_d, ptr_q, ptr_d, rr_s_q, rr_s_d, msg_syn_q, msg_syn_d;
  logic [YW-1:0]   bc_q, bc_d;
  logic [KW-1:0]   rr_i_q, rr_i_d;
  logic [IW-1:0]   pos_q, pos_d, ff_idx_q, ff_idx_d, sel_idx_q, sel_idx_d;
  logic [IW-1:0]   clr_idx_q, clr_idx_d, ins_idx_q, ins_idx_d;
  logic            ff_found_q, ff_found_d, sel_found_q, sel_found_d;
  logic            clr_en_q, clr_en_d, ins_en_q, ins_en_d, steal_q, steal_d;
  logic [CW-1:0]   act_q, act_d, k_q, k_d;
  logic [31:0]     sel_age_q, sel_age_d, age_q, age_d, rnd_q, rnd_d;
  logic [6:0]      sel_vel_q, sel_vel_d, sel_note_q, sel_note_d;
  logic [YW-1:0]   sel_syn_q, sel_syn_d;
  logic [NW-1:0]   notes_q [MAX_SYNTHS];
  logic            n_inc, n_dec;
  logic [YW-1:0]   n_idx;
  logic            div_start, div_done;
  logic [CW-1:0]   div_rem;
  logic            pick, scan_last, in_acc;

  // output register
  logic       out_valid_q, out_free, emit;
  logic [7:0] out_status_q, o_status;
  logic [6:0] out_d1_q, out_d2_q, o_d1, o_d2;
  logic       out_msg_q, out_hdl_q, out_last_q, o_msg, o_last;

  function automatic logic [7:0] on_synth(input logic [7:0] st, input logic [4:0] first,
                                          input logic [YW-1:0] syn);
    logic [4:0] ch;
    ch = first + 5'({1'b0, syn}) - 5'd1;
    return {st[7:4], ch[3:0]};
  endfunction

  assign head      = row_q[0];
  assign scan_last = (pos_q == IW'(VOICE_SLOTS - 1));
  assign in_ready_o = (st_q == S_IDLE);
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    new_v        = '0;
    new_v.active = 1'b1;
    new_v.src    = in_status_q[3:0];
    new_v.note   = in_d1_q;
    new_v.vel    = in_d2_q;
    new_v.synth  = tgt_q;
    new_v.age    = age_q;
    tail         = head;
    if (st_q == S_WRITE) begin
      if (ins_en_q && (pos_q == ins_idx_q)) begin
        tail = new_v;
      end else if (clr_en_q && (pos_q == clr_idx_q)) begin
        tail.active = 1'b0;
      end
    end
  end

  assign cell_ctl.clr   = cfg_clr;
  assign cell_ctl.shift = (st_q == S_SCAN) || (st_q == S_WRITE);

  for (genvar g = 0; g < VOICE_SLOTS; g++) begin : g_cell
    if (g == VOICE_SLOTS - 1) begin : g_tail
      assign cell_in[g] = tail;
    end else begin : g_link
      assign cell_in[g] = row_q[g+1];
    end
    mpvd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .d_i    (cell_in[g]),
      .q_o    (row_q[g])
    );
  end

  mpvd_mod #(.DIV_W(CW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd_q),
    .divisor_i  (act_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    pick = 1'b0;
    case (op_q)
      OP_OFF: pick = head.active && (head.src == in_status_q[3:0]) && (head.note == in_d1_q)
                     && (!sel_found_q || (head.age > sel_age_q));
      OP_VICT: begin
        if (eff.mode == mpvd_pkg::MODE_QUIET) begin
          pick = head.active && (!sel_found_q || (head.vel < sel_vel_q)
                 || ((head.vel == sel_vel_q) && (head.age < sel_age_q)));
        end else begin
          pick = head.active && (!sel_found_q || (head.age < sel_age_q));
        end
      end
      OP_KTH:  pick = head.active && !sel_found_q && (act_q == k_q);
      default: pick = 1'b0;
    endcase
  end

  always_comb begin
    st_d        = st_q;
    op_d        = op_q;
    hdl_d       = hdl_q;
    tgt_d       = tgt_q;
    ptr_d       = ptr_q;
    rr_s_d      = rr_s_q;
    rr_i_d      = rr_i_q;
    msg_syn_d   = msg_syn_q;
    bc_d        = bc_q;
    pos_d       = pos_q;
    ff_found_d  = ff_found_q;
    ff_idx_d    = ff_idx_q;
    sel_found_d = sel_found_q;
    sel_idx_d   = sel_idx_q;
    sel_age_d   = sel_age_q;
    sel_vel_d   = sel_vel_q;
    sel_note_d  = sel_note_q;
    sel_syn_d   = sel_syn_q;
    act_d       = act_q;
    k_d         = k_q;
    clr_en_d    = clr_en_q;
    clr_idx_d   = clr_idx_q;
    ins_en_d    = ins_en_q;
    ins_idx_d   = ins_idx_q;
    steal_d     = steal_q;
    age_d       = age_q;
    rnd_d       = rnd_q;
    n_inc       = 1'b0;
    n_dec       = 1'b0;
    n_idx       = sel_syn_q;
    div_start   = 1'b0;
    emit        = 1'b0;
    o_status    = '0;
    o_d1        = '0;
    o_d2        = '0;
    o_msg       = 1'b1;
    o_last      = 1'b1;

    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          hdl_d = 1'b1;
          if (!en_q || !status_byte_i[7] || (status_byte_i[7:4] == mpvd_pkg::TYPE_SYSTEM)) begin
            hdl_d = 1'b0;
            st_d  = S_NOMSG;
          end else if ((status_byte_i[7:4] == mpvd_pkg::TYPE_NOTE_ON) && (data_two_i != 7'd0)) begin
            rr_i_d = '0;
            rr_s_d = ptr_q;
            st_d   = S_RR;
          end else if ((status_byte_i[7:4] == mpvd_pkg::TYPE_NOTE_OFF)
                       || (status_byte_i[7:4] == mpvd_pkg::TYPE_NOTE_ON)) begin
            op_d        = OP_OFF;
            pos_d       = '0;
            ff_found_d  = 1'b0;
            sel_found_d = 1'b0;
            act_d       = '0;
            st_d        = S_SCAN;
          end else begin
            bc_d = '0;
            st_d = S_BCAST;
          end
        end
      end

      S_RR: begin
        if (KW'(notes_q[rr_s_q[SW-1:0]]) < KW'(eff.notes)) begin
          tgt_d       = rr_s_q;
          ptr_d       = wrap_next(rr_s_q, eff.count);
          op_d        = OP_FREE;
          pos_d       = '0;
          ff_found_d  = 1'b0;
          sel_found_d = 1'b0;
          act_d       = '0;
          st_d        = S_SCAN;
        end else if ((rr_i_q + KW'(1)) == eff.count) begin
          pos_d       = '0;
          ff_found_d  = 1'b0;
          sel_found_d = 1'b0;
          act_d       = '0;
          if (eff.mode == mpvd_pkg::MODE_DROP) begin
            st_d = S_NOMSG;
          end else if (eff.mode == mpvd_pkg::MODE_RANDOM) begin
            rnd_d = mpvd_pkg::xorshift(rnd_q);
            op_d  = OP_CNT;
            st_d  = S_SCAN;
          end else begin
            op_d = OP_VICT;
            st_d = S_SCAN;
          end
        end else begin
          rr_i_d = rr_i_q + KW'(1);
          rr_s_d = wrap_next(rr_s_q, eff.count);
        end
      end

      S_SCAN: begin
        if (!head.active && !ff_found_q) begin
          ff_found_d = 1'b1;
          ff_idx_d   = pos_q;
        end
        if (head.active) begin
          act_d = act_q + CW'(1);
        end
        if (pick) begin
          sel_found_d = 1'b1;
          sel_idx_d   = pos_q;
          sel_age_d   = head.age;
          sel_vel_d   = head.vel;
          sel_note_d  = head.note;
          sel_syn_d   = head.synth;
        end
        pos_d = pos_q + IW'(1);
        if (scan_last) begin
          pos_d = '0;
          st_d  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        clr_en_d  = 1'b0;
        ins_en_d  = 1'b0;
        steal_d   = 1'b0;
        pos_d     = '0;
        case (op_q)
          OP_OFF: begin
            if (!sel_found_q) begin
              st_d = S_NOMSG;
            end else begin
              clr_en_d  = 1'b1;
              clr_idx_d = sel_idx_q;
              msg_syn_d = sel_syn_q;
              n_dec     = 1'b1;
              st_d      = S_WRITE;
            end
          end
          OP_FREE: begin
            if (!ff_found_q) begin
              st_d = S_NOMSG;
            end else begin
              ins_en_d  = 1'b1;
              ins_idx_d = ff_idx_q;
              msg_syn_d = tgt_q;
              n_inc     = 1'b1;
              n_idx     = tgt_q;
              age_d     = age_q + 32'd1;
              st_d      = S_WRITE;
            end
          end
          OP_CNT: begin
            div_start = 1'b1;
            st_d      = S_DIV;
          end
          default: begin
            if ((eff.mode == mpvd_pkg::MODE_QUIET) && !(in_d2_q > sel_vel_q)) begin
              st_d = S_NOMSG;
            end else begin
              clr_en_d  = 1'b1;
              clr_idx_d = sel_idx_q;
              ins_en_d  = 1'b1;
              ins_idx_d = (ff_found_q && (ff_idx_q < sel_idx_q)) ? ff_idx_q : sel_idx_q;
              tgt_d     = sel_syn_q;
              msg_syn_d = sel_syn_q;
              ptr_d     = wrap_next(sel_syn_q, eff.count);
              age_d     = age_q + 32'd1;
              steal_d   = 1'b1;
              st_d      = S_WRITE;
            end
          end
        endcase
      end

      S_DIV: begin
        if (div_done) begin
          k_d         = div_rem;
          op_d        = OP_KTH;
          pos_d       = '0;
          ff_found_d  = 1'b0;
          sel_found_d = 1'b0;
          act_d       = '0;
          st_d        = S_SCAN;
        end
      end

      S_WRITE: begin
        pos_d = pos_q + IW'(1);
        if (scan_last) begin
          pos_d = '0;
          st_d  = S_EMIT_A;
        end
      end

      S_EMIT_A: begin
        if (out_free) begin
          emit = 1'b1;
          if (steal_q) begin
            o_status = on_synth({mpvd_pkg::TYPE_NOTE_OFF, 4'h0}, eff.first, sel_syn_q);
            o_d1     = sel_note_q;
            o_last   = 1'b0;
            st_d     = S_EMIT_B;
          end else begin
            o_status = on_synth(in_status_q, eff.first, msg_syn_q);
            o_d1     = in_d1_q;
            o_d2     = in_d2_q;
            st_d     = S_IDLE;
          end
        end
      end

      S_EMIT_B: begin
        if (out_free) begin
          emit     = 1'b1;
          o_status = on_synth(in_status_q, eff.first, msg_syn_q);
          o_d1     = in_d1_q;
          o_d2     = in_d2_q;
          st_d     = S_IDLE;
        end
      end

      S_NOMSG: begin
        if (out_free) begin
          emit  = 1'b1;
          o_msg = 1'b0;
          st_d  = S_IDLE;
        end
      end

      S_BCAST: begin
        if (out_free) begin
          emit     = 1'b1;
          o_status = on_synth(in_status_q, eff.first, bc_q);
          o_d1     = in_d1_q;
          o_d2     = in_d2_q;
          o_last   = ((KW'({1'b0, bc_q}) + KW'(1)) == eff.count);
          bc_d     = bc_q + YW'(1);
          if (o_last) begin
            st_d = S_IDLE;
          end
        end
      end

      default: st_d = S_IDLE;
    endcase

    if (cfg_clr) begin
      ptr_d = '0;
      age_d = '0;
      rnd_d = mpvd_pkg::RANDOM_SEED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      op_q        <= OP_OFF;
      hdl_q       <= 1'b0;
      ptr_q       <= '0;
      age_q       <= '0;
      rnd_q       <= mpvd_pkg::RANDOM_SEED;
      pos_q       <= '0;
      ff_found_q  <= 1'b0;
      sel_found_q <= 1'b0;
      clr_en_q    <= 1'b0;
      ins_en_q    <= 1'b0;
      steal_q     <= 1'b0;
      act_q       <= '0;
      rr_i_q      <= '0;
      bc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      op_q        <= op_d;
      hdl_q       <= hdl_d;
      ptr_q       <= ptr_d;
      age_q       <= age_d;
      rnd_q       <= rnd_d;
      pos_q       <= pos_d;
      ff_found_q  <= ff_found_d;
      sel_found_q <= sel_found_d;
      clr_en_q    <= clr_en_d;
      ins_en_q    <= ins_en_d;
      steal_q     <= steal_d;
      act_q       <= act_d;
      rr_i_q      <= rr_i_d;
      bc_q        <= bc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_status_q <= status_byte_i;
      in_d1_q     <= data_one_i;
      in_d2_q     <= data_two_i;
    end
    tgt_q      <= tgt_d;
    rr_s_q     <= rr_s_d;
    msg_syn_q  <= msg_syn_d;
    ff_idx_q   <= ff_idx_d;
    sel_idx_q  <= sel_idx_d;
    sel_age_q  <= sel_age_d;
    sel_vel_q  <= sel_vel_d;
    sel_note_q <= sel_note_d;
    sel_syn_q  <= sel_syn_d;
    clr_idx_q  <= clr_idx_d;
    ins_idx_q  <= ins_idx_d;
    k_q        <= k_d;
    if (emit) begin
      out_status_q <= o_status;
      out_d1_q     <= o_d1;
      out_d2_q     <= o_d2;
      out_msg_q    <= o_msg;
      out_hdl_q    <= hdl_q;
      out_last_q   <= o_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SYNTHS; i++) begin
        notes_q[i] <= '0;
      end
    end else if (cfg_clr) begin
      for (int i = 0; i < MAX_SYNTHS; i++) begin
        notes_q[i] <= '0;
      end
    end else if (n_inc) begin
      notes_q[n_idx[SW-1:0]] <= notes_q[n_idx[SW-1:0]] + NW'(1);
    end else if (n_dec && (notes_q[n_idx[SW-1:0]] != '0)) begin
      notes_q[n_idx[SW-1:0]] <= notes_q[n_idx[SW-1:0]] - NW'(1);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_data_one_o = out_d1_q;
  assign out_data_two_o = out_d2_q;
  assign has_message_o  = out_msg_q;
  assign handled_o      = out_hdl_q;
  assign last_of_run_o  = out_last_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == S_DIV))
    else $error("remainder finished outside its wait state");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == S_SCAN) || (st_q == S_WRITE)) |-> (pos_q <= IW'(VOICE_SLOTS - 1)))
    else $error("ring position out of range");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("output register overwritten");

endmodule
